// ----- hdl/mjr_pkg.sv -----
package mjr_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CMP_BITS   = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;
  localparam int MUL_BITS   = 35;
  localparam int SUM_BITS   = MUL_BITS + 1;
  localparam int ROUND_SHIFT = 9;

  localparam logic signed [SUM_BITS-1:0] DRIVE_MAX  = SUM_BITS'(32767);
  localparam logic signed [SUM_BITS-1:0] DRIVE_MIN  = -SUM_BITS'(32767);
  localparam logic signed [SUM_BITS-1:0] ROUND_BIAS = SUM_BITS'(256);

  typedef enum logic [2:0] {
    REG_CURRENT_LIMIT  = 3'd0,
    REG_SETTLE_TICKS   = 3'd1,
    REG_REVERSE_TICKS  = 3'd2,
    REG_SPEED_SETPOINT = 3'd3,
    REG_GAIN_P         = 3'd4,
    REG_FEEDFORWARD    = 3'd5
  } mjr_reg_t;

  typedef struct packed {
    logic [11:0] current_limit;
    logic [15:0] settle_ticks;
    logic [15:0] reverse_ticks;
    logic [14:0] speed_setpoint;
    logic [15:0] gain_p;
    logic [14:0] feedforward;
  } mjr_cfg_t;

  typedef struct packed {
    logic direction;
    logic reversed;
  } mjr_jam_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

// ----- hdl/mjr_in_if.sv -----
interface mjr_in_if;
  import mjr_pkg::*;

  logic              valid;
  logic              ready;
  logic [11:0]       motor_current;
  logic signed [15:0] motor_speed;

  modport source (output valid, output motor_current, output motor_speed, input ready);
  modport sink (input valid, input motor_current, input motor_speed, output ready);
endinterface

// ----- hdl/mjr_out_if.sv -----
interface mjr_out_if;
  import mjr_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [15:0] drive_power;
  logic               direction;
  logic               reversed;

  modport source (output valid, output drive_power, output direction, output reversed,
                  input ready);
  modport sink (input valid, input drive_power, input direction, input reversed,
                output ready);
endinterface

// ----- hdl/motor_jam_reverse_controller.sv -----
// Motor jam-reverse controller.
// in_ch carries one control tick per transfer: motor_current (1/16 A) and
// motor_speed (signed RPM). out_ch returns one result per tick: drive_power
// (Q1.15, clamped to +/-32767), the run direction after the tick, and a
// reversed flag for the tick that flipped it.
// Registers are written over the APB port at byte address 4*index; pready is
// always high, and reads return the stored value.
// A tick is captured in an input register, then the counters, direction and
// drive are computed combinationally into the output register. A result is
// offered once its tick has passed through the input register into the
// output register. One tick per cycle is accepted while out_ch is ready; the
// counter update and the gain multiply are done in the same cycle.
// Reset clears both registers and the counters, sets direction forward and
// restores register defaults. When out_ch stalls, the output register holds
// its result, the input register holds one more tick, and in_ch ready drops
// until the result is taken.
module motor_jam_reverse_controller (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mjr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [mjr_pkg::DATA_BITS-1:0] pwdata,
  output logic [mjr_pkg::DATA_BITS-1:0] prdata,
  output logic                        pready,
  mjr_in_if.sink                      in_ch,
  mjr_out_if.source                   out_ch
);
  import mjr_pkg::*;

  mjr_cfg_t           cfg;
  mjr_jam_t           jam;
  logic               a_valid;
  logic [11:0]        a_current;
  logic signed [15:0] a_speed;
  logic               advance;
  logic               step;
  logic signed [15:0] drive_next;
  logic               out_valid;
  logic signed [15:0] out_drive;
  logic               out_direction;
  logic               out_reversed;

  mjr_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign advance     = ~out_valid | out_ch.ready;
  assign step        = a_valid & advance;
  assign in_ch.ready = ~a_valid | advance;

  mjr_jam u_jam (
    .clk, .rst, .step, .motor_current(a_current), .cfg, .jam
  );

  mjr_drive u_drive (
    .motor_speed(a_speed), .direction(jam.direction), .cfg, .drive_power(drive_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        a_valid <= 1'b1;
      end else if (advance) begin
        a_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_current <= in_ch.motor_current;
      a_speed   <= in_ch.motor_speed;
    end
    if (step) begin
      out_drive     <= drive_next;
      out_direction <= jam.direction;
      out_reversed  <= jam.reversed;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.drive_power = out_drive;
  assign out_ch.direction   = out_direction;
  assign out_ch.reversed    = out_reversed;

endmodule

// ----- hdl/mjr_regs.sv -----
module mjr_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mjr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [mjr_pkg::DATA_BITS-1:0] pwdata,
  output logic [mjr_pkg::DATA_BITS-1:0] prdata,
  output logic                        pready,
  output mjr_pkg::mjr_cfg_t           cfg
);
  import mjr_pkg::*;

  mjr_reg_t sel;
  logic     wr_en;

  assign sel    = mjr_reg_t'(paddr[ADDR_BITS-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.current_limit  <= 12'd240;
      cfg.settle_ticks   <= 16'd75;
      cfg.reverse_ticks  <= 16'd35;
      cfg.speed_setpoint <= 15'd0;
      cfg.gain_p         <= 16'd2852;
      cfg.feedforward    <= 15'd4424;
    end else if (wr_en) begin
      case (sel)
        REG_CURRENT_LIMIT:  cfg.current_limit  <= pwdata[11:0];
        REG_SETTLE_TICKS:   cfg.settle_ticks   <= pwdata[15:0];
        REG_REVERSE_TICKS:  cfg.reverse_ticks  <= pwdata[15:0];
        REG_SPEED_SETPOINT: cfg.speed_setpoint <= pwdata[14:0];
        REG_GAIN_P:         cfg.gain_p         <= pwdata[15:0];
        REG_FEEDFORWARD:    cfg.feedforward    <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_CURRENT_LIMIT:  prdata = DATA_BITS'(cfg.current_limit);
      REG_SETTLE_TICKS:   prdata = DATA_BITS'(cfg.settle_ticks);
      REG_REVERSE_TICKS:  prdata = DATA_BITS'(cfg.reverse_ticks);
      REG_SPEED_SETPOINT: prdata = DATA_BITS'(cfg.speed_setpoint);
      REG_GAIN_P:         prdata = DATA_BITS'(cfg.gain_p);
      REG_FEEDFORWARD:    prdata = DATA_BITS'(cfg.feedforward);
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- hdl/mjr_jam.sv -----
module mjr_jam (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [11:0]       motor_current,
  input  mjr_pkg::mjr_cfg_t cfg,
  output mjr_pkg::mjr_jam_t jam
);
  import mjr_pkg::*;

  logic                  run_direction;
  logic [COUNT_BITS-1:0] settle_count;
  logic [COUNT_BITS-1:0] overcurrent_count;
  logic                  overcurrent_running;

  logic [COUNT_BITS-1:0] settle_inc;
  logic [COUNT_BITS-1:0] oc_inc;
  logic                  active;
  logic                  over;
  logic                  flip;

  logic                  run_direction_next;
  logic [COUNT_BITS-1:0] settle_count_next;
  logic [COUNT_BITS-1:0] overcurrent_count_next;
  logic                  overcurrent_running_next;

  always_comb begin
    settle_inc = sat_inc(settle_count);
    oc_inc     = overcurrent_running ? sat_inc(overcurrent_count) : overcurrent_count;
    active     = CMP_BITS'(settle_inc) > CMP_BITS'(cfg.settle_ticks);
    over       = motor_current > cfg.current_limit;
    flip       = active & over & (CMP_BITS'(oc_inc) > CMP_BITS'(cfg.reverse_ticks));

    run_direction_next       = run_direction ^ flip;
    settle_count_next        = flip ? '0 : settle_inc;
    overcurrent_count_next   = (active & ~over) ? '0 : oc_inc;
    overcurrent_running_next = active ? over : overcurrent_running;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_direction       <= 1'b0;
      settle_count        <= '0;
      overcurrent_count   <= '0;
      overcurrent_running <= 1'b0;
    end else if (step) begin
      run_direction       <= run_direction_next;
      settle_count        <= settle_count_next;
      overcurrent_count   <= overcurrent_count_next;
      overcurrent_running <= overcurrent_running_next;
    end
  end

  assign jam.direction = run_direction_next;
  assign jam.reversed  = flip;

`ifndef SYNTHESIS
  a_flip_restarts_settle: assert property (@(posedge clk) disable iff (rst)
    step && flip |=> settle_count == '0 && overcurrent_running)
    else $error("reversal did not restart settle count");

  a_low_current_clears: assert property (@(posedge clk) disable iff (rst)
    step && active && !over |=> overcurrent_count == '0 && !overcurrent_running)
    else $error("low current did not clear overcurrent state");

  a_flip_toggles_dir: assert property (@(posedge clk) disable iff (rst)
    step && flip |=> run_direction != $past(run_direction))
    else $error("reversal did not toggle direction");

  a_reset_state: assert property (@(posedge clk)
    rst |=> settle_count == '0 && overcurrent_count == '0 && !run_direction)
    else $error("state not cleared by reset");
`endif

endmodule

// ----- hdl/mjr_drive.sv -----
module mjr_drive (
  input  logic signed [15:0] motor_speed,
  input  logic               direction,
  input  mjr_pkg::mjr_cfg_t  cfg,
  output logic signed [15:0] drive_power
);
  import mjr_pkg::*;

  logic signed [17:0]          setpoint;
  logic signed [17:0]          target;
  logic signed [17:0]          error;
  logic signed [MUL_BITS-1:0]  product;
  logic signed [SUM_BITS-1:0]  scaled;
  logic signed [SUM_BITS-1:0]  ff;
  logic signed [SUM_BITS-1:0]  sum;
  logic signed [SUM_BITS-1:0]  clamped;

  always_comb begin
    setpoint = $signed({3'b000, cfg.speed_setpoint});
    target   = direction ? -setpoint : setpoint;
    error    = target - 18'(motor_speed);
    product  = $signed({1'b0, cfg.gain_p}) * error;
    scaled   = (SUM_BITS'(product) + ROUND_BIAS) >>> ROUND_SHIFT;
    ff       = $signed({{(SUM_BITS - 15){1'b0}}, cfg.feedforward});
    sum      = direction ? scaled - ff : scaled + ff;
    if (sum > DRIVE_MAX) begin
      clamped = DRIVE_MAX;
    end else if (sum < DRIVE_MIN) begin
      clamped = DRIVE_MIN;
    end else begin
      clamped = sum;
    end
    drive_power = clamped[15:0];
  end

endmodule
